// File: rtl/lkv_pkg.sv
// Shared types and constants of the LRU key/value cache.
// No dependencies; every other file in rtl/ but lkv_match refers to it by scoped names.
package lkv_pkg;

  // Width of the key, value and result fields on the stream ports.
  localparam int unsigned FIELD_BITS = 32;

  // Width of the capacity register and its value after reset.
  localparam int unsigned CFG_BITS = 5;
  localparam logic [CFG_BITS-1:0] CFG_CAPACITY_RESET = 5'd16;

  // Result of a get that misses.
  localparam logic [FIELD_BITS-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  // Result of every put.
  localparam logic [FIELD_BITS-1:0] PUT_VALUE = 32'h0000_0000;

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_PUT = 1'b1
  } req_e;

  // Recency update requested of the rank tracker for one slot.
  typedef struct packed {
    logic touch;   // make a valid slot the most recent
    logic insert;  // fill a free slot as the most recent
  } rank_cmd_t;

endpackage

// File: rtl/lkv_match.sv
// Parallel key comparators over all slots with a lowest-index hit select.
// Depends on nothing but its parameters.
module lkv_match #(
  parameter  int unsigned CAPACITY = 16,
  parameter  int unsigned KEY_BITS = 32,
  localparam int unsigned IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic [KEY_BITS-1:0] keys_i [CAPACITY],
  input  logic [CAPACITY-1:0] valid_i,
  input  logic [KEY_BITS-1:0] key_i,
  output logic                hit_o,
  output logic [IW-1:0]       hit_idx_o
);

  logic [CAPACITY-1:0] match;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = valid_i[i] && (keys_i[i] == key_i);
    end
  end

  // Keys held in valid slots are distinct, so the priority only settles ties
  // that cannot arise.
  always_comb begin
    hit_idx_o = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx_o = IW'(i);
      end
    end
  end

  assign hit_o = |match;

endmodule

// File: rtl/lkv_rank.sv
// Valid flags, recency ranks and occupancy of all slots, with the victim and
// free-slot selection. Depends on lkv_pkg for the update command type.
module lkv_rank #(
  parameter  int unsigned CAPACITY = 16,
  localparam int unsigned IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkv_pkg::rank_cmd_t  cmd_i,
  input  logic [IW-1:0]       slot_i,
  output logic [CAPACITY-1:0] valid_o,
  output logic [CW-1:0]       occupied_o,
  output logic [IW-1:0]       victim_o,
  output logic [IW-1:0]       free_o,
  output logic                free_any_o
);

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [IW-1:0]       rank_q [CAPACITY];
  logic [IW-1:0]       rank_d [CAPACITY];
  logic [CW-1:0]       occ_q, occ_d;
  logic [IW-1:0]       cur_rank;
  logic [IW-1:0]       last_rank;

  assign cur_rank  = rank_q[slot_i];
  // Valid slots always hold the ranks 0 to occupancy minus one, each once.
  assign last_rank = IW'(occ_q - CW'(1));

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    occ_d   = occ_q;
    if (cmd_i.touch) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid_q[i] && (IW'(i) != slot_i) && (rank_q[i] < cur_rank)) begin
          rank_d[i] = rank_q[i] + IW'(1);
        end
      end
      rank_d[slot_i] = '0;
    end
    if (cmd_i.insert) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + IW'(1);
        end
      end
      valid_d[slot_i] = 1'b1;
      rank_d[slot_i]  = '0;
      occ_d           = occ_q + CW'(1);
    end
  end

  always_comb begin
    victim_o = '0;
    free_o   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (valid_q[i] && (rank_q[i] == last_rank)) begin
        victim_o = IW'(i);
      end
      if (!valid_q[i]) begin
        free_o = IW'(i);
      end
    end
  end

  assign free_any_o = ~&valid_q;
  assign valid_o    = valid_q;
  assign occupied_o = occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      rank_q  <= rank_d;
    end
  end

endmodule

// File: rtl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
// Requests pass through an input register and a result register; one item per cycle
// while the result stream does not stall. The rate is set by the key match and rank update
// that sit between the input register and the result register.
// Reset clears the valid flags, ranks and occupancy at once and sets the
// capacity register to 16; key and value storage is not cleared.
module lru_key_value_cache #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Capacity register write.
  input  logic                          cfg_we_i,
  input  logic [lkv_pkg::CFG_BITS-1:0]  cfg_wdata_i,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*lkv_pkg::FIELD_BITS-1:0] s_axis_tdata,  // lookup_key, write_value
  input  logic [0:0]                    s_axis_tuser,   // req_type
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lkv_pkg::FIELD_BITS-1:0] m_axis_tdata,  // read_value
  output logic [0:0]                    m_axis_tuser    // found
);

  localparam int unsigned FB   = lkv_pkg::FIELD_BITS;
  localparam int unsigned IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > lkv_pkg::CFG_BITS) ? CW + 1 : lkv_pkg::CFG_BITS + 1;

  // Configuration.
  logic [lkv_pkg::CFG_BITS-1:0] cap_q;

  // Input register.
  logic                 in_valid_q;
  lkv_pkg::req_e        req_q;
  logic [FB-1:0]        key_in_q;
  logic [FB-1:0]        val_in_q;

  // Result register.
  logic                 out_valid_q;
  logic                 found_q, found_d;
  logic [FB-1:0]        data_q, data_d;

  // Storage.
  logic [KEY_BITS-1:0]          key_q [CAPACITY];
  logic signed [VALUE_BITS-1:0] val_q [CAPACITY];

  logic                         fire;
  logic [KEY_BITS-1:0]          key_k;
  logic signed [VALUE_BITS-1:0] val_v;
  logic                         hit;
  logic [IW-1:0]                hit_idx;
  logic [CAPACITY-1:0]          valid;
  logic [CW-1:0]                occupied;
  logic [IW-1:0]                victim;
  logic [IW-1:0]                free_slot;
  logic                         free_any;
  logic [CMPW-1:0]              cap_ext, cap_eff;
  logic                         full;
  lkv_pkg::rank_cmd_t           cmd;
  logic [IW-1:0]                slot;
  logic                         wr_key, wr_val;
  logic signed [VALUE_BITS-1:0] hit_value;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  // Keys and values are sign-extended or truncated from the field width.
  assign key_k = KEY_BITS'(signed'(key_in_q));
  assign val_v = VALUE_BITS'(signed'(val_in_q));

  lkv_match #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_match (
    .keys_i    (key_q),
    .valid_i   (valid),
    .key_i     (key_k),
    .hit_o     (hit),
    .hit_idx_o (hit_idx)
  );

  lkv_rank #(
    .CAPACITY (CAPACITY)
  ) u_rank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .slot_i     (slot),
    .valid_o    (valid),
    .occupied_o (occupied),
    .victim_o   (victim),
    .free_o     (free_slot),
    .free_any_o (free_any)
  );

  // A capacity of zero behaves as one, and one above CAPACITY as CAPACITY.
  assign cap_ext = CMPW'(cap_q);
  always_comb begin
    priority if (cap_ext == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_ext > CMPW'(CAPACITY)) begin
      cap_eff = CMPW'(CAPACITY);
    end else begin
      cap_eff = cap_ext;
    end
  end
  assign full = CMPW'(occupied) >= cap_eff;

  assign hit_value = val_q[hit_idx];

  always_comb begin
    cmd     = '0;
    slot    = hit_idx;
    wr_key  = 1'b0;
    wr_val  = 1'b0;
    found_d = hit;
    data_d  = lkv_pkg::PUT_VALUE;
    unique case (req_q)
      lkv_pkg::REQ_GET: begin
        cmd.touch = fire && hit;
        data_d    = hit ? FB'(hit_value) : lkv_pkg::MISS_VALUE;
      end
      lkv_pkg::REQ_PUT: begin
        priority if (hit) begin
          wr_val    = fire;
          cmd.touch = fire;
        end else if (full) begin
          // The least recent entry gives up its slot; occupancy is unchanged.
          slot      = victim;
          wr_key    = fire;
          wr_val    = fire;
          cmd.touch = fire;
        end else begin
          slot       = free_slot;
          wr_key     = fire && free_any;
          wr_val     = fire && free_any;
          cmd.insert = fire && free_any;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_key) begin
      key_q[slot] <= key_k;
    end
    if (wr_val) begin
      val_q[slot] <= val_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lkv_pkg::CFG_CAPACITY_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q    <= lkv_pkg::req_e'(s_axis_tuser[0]);
      key_in_q <= s_axis_tdata[FB-1:0];
      val_in_q <= s_axis_tdata[2*FB-1:FB];
    end
    if (fire) begin
      found_q <= found_d;
      data_q  <= data_d;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = data_q;
  assign m_axis_tuser[0] = found_q;

endmodule

// File: rtl/lkv_checker.sv
// Port-level assertions for the LRU key/value cache and their bind.
// Depends on lkv_pkg and attaches to lru_key_value_cache.
module lkv_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [lkv_pkg::FIELD_BITS-1:0]    m_axis_tdata,
  input logic [0:0]                        m_axis_tuser
);

  // An accepted item is followed by a result, through the input register and the result register.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
    else $error("accepted item produced no result");

  // With the result register empty the input side is never held off.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while no result was pending");

  // A result without a hit is either a get miss or a put.
  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      ((m_axis_tdata == lkv_pkg::MISS_VALUE) || (m_axis_tdata == lkv_pkg::PUT_VALUE)))
    else $error("result without a hit carries a stored value");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: verif/lru_key_value_cache_checker.sv
// Checker for the LRU key/value cache: predicts each result from the request stream
// and compares it with the result stream. Depends on lkv_pkg from rtl/.
module lru_key_value_cache_checker #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lkv_pkg::CFG_BITS-1:0]        cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [2*lkv_pkg::FIELD_BITS-1:0]    s_axis_tdata,   // lookup_key, write_value
  input  logic [0:0]                          s_axis_tuser,   // req_type
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [lkv_pkg::FIELD_BITS-1:0]      m_axis_tdata,   // read_value
  input  logic [0:0]                          m_axis_tuser,   // found
  output int                                  mismatch_count_o,
  output int                                  pending_results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  typedef struct packed {
    logic                  found;
    logic [FIELD_BITS-1:0] read_value;
  } lookup_result_t;

  logic [FIELD_BITS-1:0]    slot_key   [SLOTS];
  logic [FIELD_BITS-1:0]    slot_value [SLOTS];
  logic                     slot_valid [SLOTS];
  logic [$clog2(SLOTS)-1:0] slot_rank  [SLOTS];
  logic [CFG_BITS-1:0]      fill_count;
  logic [CFG_BITS-1:0]      capacity_reg;

  lookup_result_t expected_results[$];
  int             mismatches;

  // A setting of zero behaves as one, and anything above the slot count as the slot count.
  function automatic int unsigned effective_capacity();
    if (capacity_reg == '0) return 1;
    if (capacity_reg > SLOTS) return SLOTS;
    return capacity_reg;
  endfunction

  // Move a slot to the front; the slots that were ahead of it each drop back one place.
  function automatic void promote(int s);
    logic [$clog2(SLOTS)-1:0] r;
    r = slot_rank[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i] = slot_rank[i] + 1'b1;
    end
    slot_rank[s] = '0;
  endfunction

  function automatic lookup_result_t serve_request(req_e kind, logic [FIELD_BITS-1:0] key,
                                                   logic [FIELD_BITS-1:0] value);
    lookup_result_t res;
    int hit;
    int victim;
    int free_slot;
    hit = -1;
    victim = -1;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
    end
    res.found = (hit >= 0);
    res.read_value = PUT_VALUE;

    if (kind == REQ_GET) begin
      if (hit >= 0) begin
        promote(hit);
        res.read_value = slot_value[hit];
      end else begin
        res.read_value = MISS_VALUE;
      end
      return res;
    end

    if (hit >= 0) begin
      slot_value[hit] = value;
      promote(hit);
      return res;
    end

    // A full cache (or one whose limit was lowered) reuses the least recent slot.
    if (fill_count >= effective_capacity()) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
      end
      if (victim >= 0) begin
        slot_key[victim] = key;
        slot_value[victim] = value;
        promote(victim);
        return res;
      end
    end

    for (int i = 0; i < SLOTS; i++) begin
      if (free_slot < 0 && !slot_valid[i]) free_slot = i;
    end
    if (free_slot >= 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i]) slot_rank[i] = slot_rank[i] + 1'b1;
      end
      slot_valid[free_slot] = 1'b1;
      slot_key[free_slot] = key;
      slot_value[free_slot] = value;
      slot_rank[free_slot] = '0;
      fill_count = fill_count + 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i] = '0;
      end
      fill_count = '0;
      capacity_reg = CFG_CAPACITY_RESET;
      expected_results.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_results_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result found=%b value=%h with nothing outstanding",
                                    m_axis_tuser[0], m_axis_tdata));
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser[0] !== want.found)
            report_mismatch($sformatf("found got %b expected %b", m_axis_tuser[0], want.found));
          if (m_axis_tdata !== want.read_value)
            report_mismatch($sformatf("read_value got %h expected %h",
                                      m_axis_tdata, want.read_value));
        end
      end
      if (cfg_we_i) capacity_reg = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(serve_request(req_e'(s_axis_tuser[0]),
                                                 s_axis_tdata[FIELD_BITS-1:0],
                                                 s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]));
      end
      mismatch_count_o <= mismatches;
      pending_results_o <= expected_results.size();
    end
  end

endmodule

// File: verif/lru_key_value_cache_tb.sv
// Top of the LRU key/value cache testbench: clock, reset, request and config stimulus.
// Depends on lkv_pkg, lru_key_value_cache and lru_key_value_cache_checker.
module lru_key_value_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [CFG_BITS-1:0]         cfg_wdata_i;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [2*FIELD_BITS-1:0]     s_axis_tdata;   // lookup_key, write_value
  logic [0:0]                  s_axis_tuser;   // req_type
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [FIELD_BITS-1:0]       m_axis_tdata;   // read_value
  logic [0:0]                  m_axis_tuser;   // found
  int                          mismatch_count;
  int                          pending_results;

  int unsigned                 send_idle_pct;
  int unsigned                 recv_idle_pct;
  logic [FIELD_BITS-1:0]       key_pool[32];

  lru_key_value_cache dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  lru_key_value_cache_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .mismatch_count_o  (mismatch_count),
    .pending_results_o (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // The result side stalls at random according to the current idling mode.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_req(req_e kind, logic [FIELD_BITS-1:0] key,
                          logic [FIELD_BITS-1:0] value);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {value, key};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Holds requests back until every outstanding result has been taken.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CFG_BITS-1:0] cap);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_random_phase(logic [CFG_BITS-1:0] cap, int unsigned n_items);
    int unsigned           pool_n;
    logic [FIELD_BITS-1:0] key;
    req_e                  kind;
    set_capacity(cap);
    // Draw keys from a pool a little larger than the capacity so hits and evictions mix.
    pool_n = $urandom_range(1, 8) + ((cap > 16) ? 16 : cap);
    for (int unsigned n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 9) == 0) key = $urandom();
      else key = key_pool[$urandom_range(0, pool_n - 1)];
      kind = ($urandom_range(0, 99) < 45) ? REQ_PUT : REQ_GET;
      send_req(kind, key, $urandom());
      if ($urandom_range(0, 99) == 0) wait_for_results();
    end
  endtask

  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 32; i++) key_pool[i] = $urandom();
    send_idle_pct = 21;
    recv_idle_pct = 63;
    rst_ni        = 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_GET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty lookup, extreme keys and values, update, hit returning all ones.
    set_capacity(5'd16);
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_req(REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_req(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_req(REQ_PUT, 32'h0000_0000, 32'h1234_5678);
    send_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_GET, 32'h0000_0001, 32'h0000_0000);

    // Capacity lowered below the occupancy: each new key replaces only the least recent one.
    set_capacity(5'd2);
    send_req(REQ_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_req(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_req(REQ_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_req(REQ_GET, 32'h5555_5555, 32'h0000_0000);
    send_req(REQ_GET, 32'hAAAA_AAAA, 32'h0000_0000);

    // A capacity of zero behaves as one.
    set_capacity(5'd0);
    send_req(REQ_PUT, 32'h0000_0001, 32'h0000_0001);
    send_req(REQ_PUT, 32'h0000_0002, 32'h0000_0002);
    send_req(REQ_GET, 32'h0000_0001, 32'h0000_0000);
    send_req(REQ_GET, 32'h0000_0002, 32'h0000_0000);

    // A capacity above the slot count behaves as the slot count.
    set_capacity(5'd31);
    send_req(REQ_PUT, 32'h0000_0003, 32'h0000_0003);
    send_req(REQ_GET, 32'h0000_0003, 32'h0000_0000);
    send_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);

    run_random_phase(5'd16, 128);
    run_random_phase(5'd1, 128);
    run_random_phase(5'd0, 128);

    send_idle_pct = 63;
    recv_idle_pct = 21;
    run_random_phase(5'd31, 128);
    run_random_phase(5'd4, 128);
    run_random_phase(5'd17, 128);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(5'd16, 128);
    run_random_phase(5'd2, 128);
    run_random_phase(CFG_BITS'($urandom_range(0, 31)), 128);

    wait_for_results();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: lru_key_value_cache.f
rtl/lkv_pkg.sv
rtl/lkv_match.sv
rtl/lkv_rank.sv
rtl/lru_key_value_cache.sv
rtl/lkv_checker.sv
verif/lru_key_value_cache_checker.sv
verif/lru_key_value_cache_tb.sv
